// ----- rtl/core/vsd_pkg.sv -----
// ----------------------------------------------------------------------------
// vsd_pkg - shared types and constants for the varint stream decoder
// Status codes, decoder state and per-byte step result, plus the
// width-code lookup used by the byte step logic.
// ----------------------------------------------------------------------------
package vsd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_LONG  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Target width codes
  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_32 = 2'd2;
  localparam logic [1:0] WCODE_64 = 2'd3;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CONT_BIT = 7;
  localparam logic [1:0] WCODE_RESET = WCODE_64;
  localparam logic [IDX_W-1:0] MAX_USED = 4'd11;

  // Partial value gathered so far
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [IDX_W-1:0]   idx;
  } dec_state_t;

  // Outcome of one byte
  typedef struct packed {
    logic               emit;
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   bytes_used;
  } step_res_t;

  // Most bytes a value may take for a width code
  function automatic logic [IDX_W-1:0] max_bytes(input logic [1:0] code);
    logic [IDX_W-1:0] m;
    unique case (code)
      WCODE_8:  m = 4'd2;
      WCODE_16: m = 4'd3;
      WCODE_32: m = 4'd5;
      WCODE_64: m = 4'd10;
      default:  m = 4'd10;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/varint_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// varint_stream_decoder_unit - unsigned LEB128 varint stream decoder
// Byte-wide input, one result per completed value or error.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle. A byte lands in an input register,
// is merged into the running value by one shift-or and limit check, and any
// result is then written into the output register, whose out_valid rises
// once the value's final byte has passed from the input register into it.
// Sustained rate is one byte per clock; the input register also holds a
// byte while a finished result waits on out_stall, so input only stalls
// when a byte that ends a value meets a full, stalled output register.
// Errors (truncated, too many bytes, out of range) report value zero and
// restart decoding at the next byte. The user must write the target width
// via the cfg port only while idle (unchecked); cfg_ready is always high.
module varint_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic [1:0]  out_status,
  output logic [3:0]  out_bytes_used,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_target_width_code
);

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  vsd_pkg::dec_state_t st_r;
  vsd_pkg::dec_state_t st_nxt;
  vsd_pkg::step_res_t  res;
  logic [1:0]          wcode_r;
  logic                out_valid_r;
  logic [63:0]         out_value_r;
  logic [1:0]          out_status_r;
  logic [3:0]          out_used_r;
  logic                out_free;
  logic                s1_adv;
  logic                in_take;

  // Per-byte decode
  vsd_byte_step u_step (
    .cur_state  (st_r),
    .data_byte  (s1_byte_r),
    .buffer_end (s1_last_r),
    .wcode      (wcode_r),
    .nxt_state  (st_nxt),
    .res        (res)
  );

  // Flow control: a byte with no result never waits on the output
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!res.emit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcode_r <= vsd_pkg::WCODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wcode_r <= cfg_target_width_code;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_buffer_end;
    end
  end

  // Decoder state advances with each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
      out_used_r   <= res.bytes_used;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_status     = out_status_r;
  assign out_bytes_used = out_used_r;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'(vsd_pkg::ST_OK)) |-> out_value == 64'd0)
    else $error("error result carries a nonzero value");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes_used != 4'd0) && (out_bytes_used <= vsd_pkg::MAX_USED))
    else $error("bytes_used out of range");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.idx <= 4'd10)
    else $error("byte index past ten");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && res.emit && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

endmodule

// ----- rtl/core/vsd_byte_step.sv -----
// ----------------------------------------------------------------------------
// vsd_byte_step - one byte of LEB128 decoding
// Combinational: merges the byte's payload into the partial value, checks
// length and range limits, and decides whether a result leaves.
// ----------------------------------------------------------------------------
module vsd_byte_step (
  input  vsd_pkg::dec_state_t cur_state,
  input  logic [7:0]          data_byte,
  input  logic                buffer_end,
  input  logic [1:0]          wcode,
  output vsd_pkg::dec_state_t nxt_state,
  output vsd_pkg::step_res_t  res
);

  logic [vsd_pkg::IDX_W-1:0]   used;
  logic                        too_long;
  logic [6:0]                  shamt_wide;
  logic [5:0]                  shamt;
  logic [vsd_pkg::VALUE_W-1:0] acc_or;
  logic                        over;

  // Byte count including this one; index never passes 10
  assign used     = cur_state.idx + 4'd1;
  assign too_long = used > vsd_pkg::max_bytes(wcode);

  // Shift of 7 * index; only used while index <= 9, so it fits 6 bits
  assign shamt_wide = {cur_state.idx, 3'b000} - {3'b000, cur_state.idx};
  assign shamt      = shamt_wide[5:0];

  // Payload bits above bit 63 fall off the top
  assign acc_or = cur_state.acc |
                  ({{(vsd_pkg::VALUE_W-7){1'b0}}, data_byte[6:0]} << shamt);

  // Range check against the target width
  always_comb begin
    unique case (wcode)
      vsd_pkg::WCODE_8:  over = |acc_or[63:8];
      vsd_pkg::WCODE_16: over = |acc_or[63:16];
      vsd_pkg::WCODE_32: over = |acc_or[63:32];
      vsd_pkg::WCODE_64: over = 1'b0;
      default:           over = 1'b0;
    endcase
  end

  // Outcome and next partial state
  always_comb begin
    res.emit       = 1'b0;
    res.status     = vsd_pkg::ST_OK;
    res.value      = '0;
    res.bytes_used = used;
    nxt_state.acc  = '0;
    nxt_state.idx  = '0;
    if (too_long) begin
      res.emit   = 1'b1;
      res.status = vsd_pkg::ST_LONG;
    end else if (!data_byte[vsd_pkg::CONT_BIT]) begin
      res.emit = 1'b1;
      if (over) begin
        res.status = vsd_pkg::ST_RANGE;
      end else begin
        res.value = acc_or;
      end
    end else if (buffer_end) begin
      res.emit   = 1'b1;
      res.status = vsd_pkg::ST_TRUNC;
    end else begin
      nxt_state.acc = acc_or;
      nxt_state.idx = used;
    end
  end

endmodule

// ----- sim/vsd_checker.sv -----
// ----------------------------------------------------------------------------
// vsd_checker - result predictor and scoreboard for the varint decoder
// Watches the byte, result and config channels. Each accepted byte is run
// through a local LEB128 decoder; results are compared in order, field by
// field, against the queue of predicted decodes.
// ----------------------------------------------------------------------------
module vsd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_value,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_bytes_used,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_target_width_code,
  output int          fail_count,
  output int          pending_results
);

  typedef struct {
    logic [63:0]      value;
    vsd_pkg::status_t status;
    logic [3:0]       bytes_used;
  } decode_t;

  decode_t     predicted_decodes[$];
  logic [1:0]  width_code;
  logic [63:0] acc_bits;
  logic [3:0]  byte_pos;
  int          errors = 0;

  // Longest encoding allowed for each target width
  function automatic int byte_limit(input logic [1:0] code);
    case (code)
      vsd_pkg::WCODE_8:  return 2;
      vsd_pkg::WCODE_16: return 3;
      vsd_pkg::WCODE_32: return 5;
      default:           return 10;
    endcase
  endfunction

  // Largest value that fits each target width
  function automatic logic [63:0] value_limit(input logic [1:0] code);
    case (code)
      vsd_pkg::WCODE_8:  return 64'h0000_0000_0000_00FF;
      vsd_pkg::WCODE_16: return 64'h0000_0000_0000_FFFF;
      vsd_pkg::WCODE_32: return 64'h0000_0000_FFFF_FFFF;
      default:           return '1;
    endcase
  endfunction

  // Advance the local decoder by one byte; queue a result if one ends here
  task automatic decode_byte(input logic [7:0] b, input logic last);
    decode_t    r;
    logic [3:0] used;
    logic       done;
    used = byte_pos + 4'd1;
    done = 1'b1;
    r.value      = '0;
    r.bytes_used = used;
    if (int'(used) > byte_limit(width_code)) begin
      // too many bytes: payload dropped, whatever the flags say
      r.status = vsd_pkg::ST_LONG;
    end else begin
      // shifts past bit 63 drop the high payload bits of the tenth byte
      acc_bits = acc_bits | ({57'd0, b[6:0]} << (7 * int'(byte_pos)));
      byte_pos = used;
      if (!b[7]) begin
        if (acc_bits > value_limit(width_code)) begin
          r.status = vsd_pkg::ST_RANGE;
        end else begin
          r.status = vsd_pkg::ST_OK;
          r.value  = acc_bits;
        end
      end else if (last) begin
        r.status = vsd_pkg::ST_TRUNC;
      end else begin
        done = 1'b0;
      end
    end
    if (done) begin
      predicted_decodes.insert(predicted_decodes.size(), r);
      acc_bits = '0;
      byte_pos = '0;
    end
  endtask

  // Compare one result beat with the oldest prediction
  task automatic check_result();
    decode_t exp;
    if (predicted_decodes.size() == 0) begin
      $error("result beat with nothing pending: value %h status %0d bytes_used %0d",
             out_value, out_status, out_bytes_used);
      errors++;
    end else begin
      exp = predicted_decodes.pop_front();
      if (out_value !== exp.value) begin
        $error("value mismatch: expected %h, actual %h", exp.value, out_value);
        errors++;
      end
      if (out_status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, out_status);
        errors++;
      end
      if (out_bytes_used !== exp.bytes_used) begin
        $error("bytes_used mismatch: expected %0d, actual %0d",
               exp.bytes_used, out_bytes_used);
        errors++;
      end
    end
  endtask

  // Channel monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      width_code = vsd_pkg::WCODE_RESET;
      acc_bits   = '0;
      byte_pos   = '0;
      predicted_decodes.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) width_code = cfg_target_width_code;
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_buffer_end);
    end
    fail_count      <= errors;
    pending_results <= predicted_decodes.size();
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - top level testbench for varint_stream_decoder_unit
// Drives directed and random LEB128 byte streams across all target widths,
// with random idling on both channels, a long receiver hold-off and a
// sender pause; vsd_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_BEATS    = 63;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_buffer_end;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;
  logic [1:0]  out_status;
  logic [3:0]  out_bytes_used;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_target_width_code;

  int fail_count;
  int pending_results;
  int beats_sent = 0;
  int gap_rate   = 0;
  bit quiet      = 1'b0;
  bit hold_request = 1'b0;

  logic [1:0] phase_codes[6] = '{vsd_pkg::WCODE_32, vsd_pkg::WCODE_64, vsd_pkg::WCODE_8,
                                 vsd_pkg::WCODE_16, vsd_pkg::WCODE_64, vsd_pkg::WCODE_8};
  int         phase_gaps[6]  = '{3, 0, 6, 0, 4, 0};

  varint_stream_decoder_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_buffer_end         (in_buffer_end),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_value             (out_value),
    .out_status            (out_status),
    .out_bytes_used        (out_bytes_used),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_target_width_code (cfg_target_width_code)
  );

  vsd_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_buffer_end         (in_buffer_end),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_value             (out_value),
    .out_status            (out_status),
    .out_bytes_used        (out_bytes_used),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_target_width_code (cfg_target_width_code),
    .fail_count            (fail_count),
    .pending_results       (pending_results)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one byte beat, optionally after a random gap, and wait for it to go in
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gap_rate != 0 && !quiet && $urandom_range(1, gap_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_buffer_end <= last;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the target width while the block is idle
  task automatic set_width(input logic [1:0] code);
    drain();
    cfg_valid             <= 1'b1;
    cfg_target_width_code <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random encoded value: mostly well formed, some truncated,
  // overlong or plain noise
  task automatic send_value(input logic [1:0] code);
    int         shape;
    int         n_bytes;
    int         limit;
    logic [7:0] b;
    logic       last;
    limit = int'(vsd_pkg::max_bytes(code));
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end else begin
      if (shape == 1) n_bytes = $urandom_range(limit + 1, 11);
      else if ($urandom_range(0, 1) == 1) n_bytes = $urandom_range(1, 2);
      else n_bytes = $urandom_range(1, limit);
      for (int i = 0; i < n_bytes; i++) begin
        b    = 8'($urandom);
        last = 1'b0;
        if (i < n_bytes - 1) begin
          b[7] = 1'b1;
        end else if (shape == 2) begin
          // truncated: continuation on the buffer's last byte
          b[7] = 1'b1;
          last = 1'b1;
        end else begin
          if (shape != 1) b[7] = 1'b0;
          if ($urandom_range(0, 1) == 1) b[6:0] = 7'($urandom_range(0, 3));
          last = ($urandom_range(0, 3) == 0);
        end
        send_byte(b, last);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  initial begin
    int idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int phase_end;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_data_byte          <= '0;
    in_buffer_end         <= 1'b0;
    cfg_valid             <= 1'b0;
    cfg_target_width_code <= vsd_pkg::WCODE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 64-bit width from reset: smallest value, end of buffer on a final byte,
    // truncation, and payload bits falling off past bit 63
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b1);
    repeat (9) send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);

    // 8-bit width: largest fit, out of range, too many bytes
    set_width(vsd_pkg::WCODE_8);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);

    // width changed in the middle of a value
    send_byte(8'h81, 1'b0);
    set_width(vsd_pkg::WCODE_16);
    send_byte(8'h81, 1'b0);
    send_byte(8'h01, 1'b0);

    // Random phases over all widths
    foreach (phase_codes[p]) begin
      set_width(phase_codes[p]);
      gap_rate  = phase_gaps[p];
      quiet     = (p == $size(phase_codes) - 1);
      phase_end = beats_sent + PHASE_BEATS;
      // back-pressure: receiver holds off while bytes keep coming
      if (p == 1) hold_request = 1'b1;
      while (beats_sent < phase_end) begin
        send_value(phase_codes[p]);
        if (p == 2 && beats_sent >= phase_end - PHASE_BEATS / 2 && gap_rate != 0) begin
          // sender pause until everything is out
          drain();
          gap_rate = 0;
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
